/* rtl/lcw_pkg.sv */
// Shared types and constants for the LCW (Format80) frame decompressor.
// Used by lcw_format80_decompressor; no dependencies.
package lcw_pkg;

	localparam int FRAME_BYTES_DEF = 65536;

	localparam int LEN_W    = 17;
	localparam int INDEX_W  = 16;
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 3;
	localparam int OP_W     = 2;

	// Input kinds
	localparam logic [OP_W-1:0] OP_START = 2'd0;
	localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

	// Result codes
	localparam logic [STATUS_W-1:0] ST_CONSUMED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_WRITTEN  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ENDED    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_STOPPED  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd4;

	// Command byte fields
	localparam logic [7:0] CMD_SHORT_MASK = 8'h80;
	localparam logic [7:0] CMD_LONG_MASK  = 8'h40;
	localparam logic [7:0] REL_CNT_MASK   = 8'h70;
	localparam logic [7:0] REL_DIST_MASK  = 8'h0F;
	localparam logic [5:0] CNT_LONG_COPY  = 6'h3F;
	localparam logic [5:0] CNT_LONG_FILL  = 6'h3E;
	localparam int         RUN_BIAS       = 3;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_CMD     = 4'd1,
		PH_REL2    = 4'd2,
		PH_LIT     = 4'd3,
		PH_FCNT_LO = 4'd4,
		PH_FCNT_HI = 4'd5,
		PH_FVAL    = 4'd6,
		PH_ACNT_LO = 4'd7,
		PH_ACNT_HI = 4'd8,
		PH_ASRC_LO = 4'd9,
		PH_ASRC_HI = 4'd10,
		PH_RUN     = 4'd11
	} phase_t;

endpackage

/* rtl/lcw_format80_decompressor.sv */
// LCW (Format80) frame decompressor: command parser, run engine and frame store.
// Depends on lcw_pkg and lcw_ram.
//
//  port group  | dir | contents
//  ------------+-----+----------------------------------------------------------
//  s_axis_*    | in  | tuser[1:0] opcode, tdata[7:0] source_byte
//  m_axis_*    | out | tuser[2:0] status, tdata[15:0] pixel_index,
//              |     | tdata[23:16] pixel_value, tdata[24] run_pending
//  cfg_*       | in  | cfg_data[16:0] frame_length
//
// One beat is taken every cycle while the output is not stalled; its result passes
// through stage s1, then the output register. The frame store is read at the accept
// edge and written when the beat leaves s1; a copy at distance one is forwarded from s1.
// Reset clears control state only; the store needs no clearing pass.
// A stalled output holds s1 and drops s_axis_tready until the output drains.
module lcw_format80_decompressor #(
	parameter int FRAME_BYTES = lcw_pkg::FRAME_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,  // [7:0] source_byte
	input  logic [lcw_pkg::OP_W-1:0]    s_axis_tuser,  // [1:0] opcode
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [31:0]                 m_axis_tdata,  // [15:0] pixel_index,
	                                                   // [23:16] pixel_value,
	                                                   // [24] run_pending
	output logic [lcw_pkg::STATUS_W-1:0] m_axis_tuser, // [2:0] status
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lcw_pkg::LEN_W-1:0]   cfg_data       // frame_length
);

	localparam int AW = $clog2(FRAME_BYTES);
	localparam logic [lcw_pkg::LEN_W-1:0] FRAME_LEN = lcw_pkg::LEN_W'(FRAME_BYTES);

	// control state
	logic [lcw_pkg::LEN_W-1:0]   frame_length_q;
	logic [lcw_pkg::LEN_W-1:0]   wp_q, wp_nx;
	lcw_pkg::phase_t             phase_q, phase_nx;
	logic [lcw_pkg::INDEX_W-1:0] run_count_q, run_count_nx;
	logic [lcw_pkg::INDEX_W-1:0] copy_src_q, copy_src_nx;
	logic [lcw_pkg::BYTE_W-1:0]  fill_value_q, fill_value_nx;
	logic                        run_is_fill_q, run_is_fill_nx;
	logic [lcw_pkg::BYTE_W-1:0]  held_byte_q, held_byte_nx;

	// per-beat decode results
	logic [lcw_pkg::STATUS_W-1:0] status_c;
	logic                         wr_c;
	logic                         mem_c;
	logic [lcw_pkg::BYTE_W-1:0]   data_c;

	// stage s1
	logic                         s1_valid_s1;
	logic [lcw_pkg::STATUS_W-1:0] s1_status_s1;
	logic                         s1_wr_s1;
	logic                         s1_mem_s1;
	logic [lcw_pkg::BYTE_W-1:0]   s1_data_s1;
	logic [AW-1:0]                s1_addr_s1;
	logic [lcw_pkg::INDEX_W-1:0]  s1_index_s1;
	logic                         s1_pend_s1;
	logic                         s1_fwd_s1;
	logic [lcw_pkg::BYTE_W-1:0]   s1_fwd_data_s1;

	// output register
	logic                         out_valid_q;
	logic [lcw_pkg::STATUS_W-1:0] out_status_q;
	logic [lcw_pkg::INDEX_W-1:0]  out_index_q;
	logic [lcw_pkg::BYTE_W-1:0]   out_value_q;
	logic                         out_pend_q;

	logic                        in_acc;
	logic                        s1_adv;
	logic [lcw_pkg::BYTE_W-1:0]  ram_rdata;
	logic [lcw_pkg::BYTE_W-1:0]  s1_value;
	logic [lcw_pkg::LEN_W-1:0]   eff_len;
	logic [lcw_pkg::LEN_W-1:0]   room;
	logic [lcw_pkg::BYTE_W-1:0]  b;

	assign cfg_ready     = 1'b1;
	assign s1_adv        = s1_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_s1 || s1_adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign b             = s_axis_tdata;

	assign eff_len = (frame_length_q < FRAME_LEN) ? frame_length_q : FRAME_LEN;
	assign room    = (wp_q < eff_len) ? (eff_len - wp_q) : '0;

	// Parse one beat against the current state.
	always_comb begin
		logic [lcw_pkg::LEN_W-1:0] lit_cnt;
		logic [lcw_pkg::LEN_W-1:0] arm_cnt;
		logic [3:0]                rel_cnt;
		logic [11:0]               rel_dist;
		logic [lcw_pkg::INDEX_W-1:0] abs_src;

		wp_nx          = wp_q;
		phase_nx       = phase_q;
		run_count_nx   = run_count_q;
		copy_src_nx    = copy_src_q;
		fill_value_nx  = fill_value_q;
		run_is_fill_nx = run_is_fill_q;
		held_byte_nx   = held_byte_q;
		status_c       = lcw_pkg::ST_CONSUMED;
		wr_c           = 1'b0;
		mem_c          = 1'b0;
		data_c         = '0;

		lit_cnt  = {11'd0, b[5:0]};
		if (lit_cnt > room) begin
			lit_cnt = room;
		end
		arm_cnt  = ({1'b0, run_count_q} > room) ? room : {1'b0, run_count_q};
		rel_cnt  = {1'b0, held_byte_q[6:4]} + 4'(lcw_pkg::RUN_BIAS);
		rel_dist = {held_byte_q[3:0] & lcw_pkg::REL_DIST_MASK[3:0], b};
		abs_src  = {b, copy_src_q[7:0]};

		case (s_axis_tuser)
			lcw_pkg::OP_START: begin
				wp_nx        = '0;
				run_count_nx = '0;
				phase_nx     = lcw_pkg::PH_CMD;
			end
			lcw_pkg::OP_TICK: begin
				if (phase_q != lcw_pkg::PH_RUN) begin
					status_c = lcw_pkg::ST_REJECTED;
				end else begin
					status_c     = lcw_pkg::ST_WRITTEN;
					wr_c         = 1'b1;
					mem_c        = !run_is_fill_q;
					data_c       = run_is_fill_q ? fill_value_q : '0;
					wp_nx        = wp_q + 1'b1;
					copy_src_nx  = copy_src_q + 1'b1;
					run_count_nx = run_count_q - 1'b1;
					if (run_count_nx == '0) begin
						phase_nx = lcw_pkg::PH_CMD;
					end
				end
			end
			lcw_pkg::OP_BYTE: begin
				case (phase_q)
					lcw_pkg::PH_CMD: begin
						if ((b & lcw_pkg::CMD_SHORT_MASK) == '0) begin
							held_byte_nx = b;
							phase_nx     = lcw_pkg::PH_REL2;
						end else if ((b & lcw_pkg::CMD_LONG_MASK) == '0) begin
							if (b[5:0] == '0) begin
								status_c = lcw_pkg::ST_ENDED;
								phase_nx = lcw_pkg::PH_IDLE;
							end else begin
								run_count_nx = lit_cnt[lcw_pkg::INDEX_W-1:0];
								phase_nx = (lit_cnt == '0) ? lcw_pkg::PH_CMD : lcw_pkg::PH_LIT;
							end
						end else if (b[5:0] == lcw_pkg::CNT_LONG_FILL) begin
							phase_nx = lcw_pkg::PH_FCNT_LO;
						end else if (b[5:0] == lcw_pkg::CNT_LONG_COPY) begin
							phase_nx = lcw_pkg::PH_ACNT_LO;
						end else begin
							run_count_nx = {10'd0, b[5:0]} + 16'(lcw_pkg::RUN_BIAS);
							phase_nx     = lcw_pkg::PH_ASRC_LO;
						end
					end
					lcw_pkg::PH_REL2: begin
						if (({1'b0, wp_q} + 18'(rel_cnt)) > {1'b0, eff_len} ||
						    rel_dist == '0 || {5'd0, rel_dist} > wp_q) begin
							status_c = lcw_pkg::ST_STOPPED;
							phase_nx = lcw_pkg::PH_IDLE;
						end else begin
							copy_src_nx    = wp_q[lcw_pkg::INDEX_W-1:0] - {4'd0, rel_dist};
							run_is_fill_nx = 1'b0;
							run_count_nx   = {12'd0, rel_cnt};
							phase_nx       = lcw_pkg::PH_RUN;
						end
					end
					lcw_pkg::PH_LIT: begin
						status_c     = lcw_pkg::ST_WRITTEN;
						wr_c         = 1'b1;
						data_c       = b;
						wp_nx        = wp_q + 1'b1;
						run_count_nx = run_count_q - 1'b1;
						if (run_count_nx == '0) begin
							phase_nx = lcw_pkg::PH_CMD;
						end
					end
					lcw_pkg::PH_FCNT_LO: begin
						run_count_nx = {8'd0, b};
						phase_nx     = lcw_pkg::PH_FCNT_HI;
					end
					lcw_pkg::PH_FCNT_HI: begin
						run_count_nx = {b, run_count_q[7:0]};
						phase_nx     = lcw_pkg::PH_FVAL;
					end
					lcw_pkg::PH_FVAL: begin
						fill_value_nx  = b;
						run_is_fill_nx = 1'b1;
						run_count_nx   = arm_cnt[lcw_pkg::INDEX_W-1:0];
						phase_nx = (arm_cnt == '0) ? lcw_pkg::PH_CMD : lcw_pkg::PH_RUN;
					end
					lcw_pkg::PH_ACNT_LO: begin
						run_count_nx = {8'd0, b};
						phase_nx     = lcw_pkg::PH_ACNT_HI;
					end
					lcw_pkg::PH_ACNT_HI: begin
						run_count_nx = {b, run_count_q[7:0]};
						phase_nx     = lcw_pkg::PH_ASRC_LO;
					end
					lcw_pkg::PH_ASRC_LO: begin
						copy_src_nx = {8'd0, b};
						phase_nx    = lcw_pkg::PH_ASRC_HI;
					end
					lcw_pkg::PH_ASRC_HI: begin
						copy_src_nx = abs_src;
						if ({1'b0, abs_src} >= wp_q) begin
							status_c = lcw_pkg::ST_STOPPED;
							phase_nx = lcw_pkg::PH_IDLE;
						end else begin
							run_is_fill_nx = 1'b0;
							run_count_nx   = arm_cnt[lcw_pkg::INDEX_W-1:0];
							phase_nx = (arm_cnt == '0) ? lcw_pkg::PH_CMD : lcw_pkg::PH_RUN;
						end
					end
					default: begin
						status_c = lcw_pkg::ST_REJECTED;
					end
				endcase
			end
			default: begin
				status_c = lcw_pkg::ST_REJECTED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= FRAME_LEN;
		end else if (cfg_valid) begin
			frame_length_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q          <= '0;
			phase_q       <= lcw_pkg::PH_IDLE;
			run_count_q   <= '0;
			copy_src_q    <= '0;
			fill_value_q  <= '0;
			run_is_fill_q <= 1'b0;
			held_byte_q   <= '0;
		end else if (in_acc) begin
			wp_q          <= wp_nx;
			phase_q       <= phase_nx;
			run_count_q   <= run_count_nx;
			copy_src_q    <= copy_src_nx;
			fill_value_q  <= fill_value_nx;
			run_is_fill_q <= run_is_fill_nx;
			held_byte_q   <= held_byte_nx;
		end
	end

	// Store data: the beat's own byte for a literal or fill; for a copy beat, forwarded from the beat in s1, else the RAM.
	assign s1_value = !s1_mem_s1 ? s1_data_s1 :
	                  s1_fwd_s1  ? s1_fwd_data_s1 : ram_rdata;

	lcw_ram #(
		.WIDTH(lcw_pkg::BYTE_W),
		.DEPTH(FRAME_BYTES)
	) u_store (
		.clk  (clk),
		.we   (s1_adv && s1_wr_s1),
		.waddr(s1_addr_s1),
		.wdata(s1_value),
		.re   (in_acc),
		.raddr(copy_src_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_acc) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_status_s1   <= status_c;
			s1_wr_s1       <= wr_c;
			s1_mem_s1      <= mem_c;
			s1_data_s1     <= data_c;
			s1_addr_s1     <= wp_q[AW-1:0];
			s1_index_s1    <= wr_c ? wp_q[lcw_pkg::INDEX_W-1:0] : '0;
			s1_pend_s1     <= (phase_nx == lcw_pkg::PH_RUN);
			// the beat in s1 writes at this same edge, so the RAM read misses it
			s1_fwd_s1      <= s1_valid_s1 && s1_wr_s1 &&
			                  (s1_addr_s1 == copy_src_q[AW-1:0]);
			s1_fwd_data_s1 <= s1_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_status_q <= s1_status_s1;
			out_index_q  <= s1_index_s1;
			out_value_q  <= s1_wr_s1 ? s1_value : '0;
			out_pend_q   <= s1_pend_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {7'd0, out_pend_q, out_value_q, out_index_q};

	// A beat can only enter s1 when the previous one leaves it.
	a_s1_drain: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s1_valid_s1 |-> s1_adv)
		else $error("s1 overwritten while stalled");

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == lcw_pkg::PH_RUN |-> run_count_q != '0)
		else $error("pending run with zero count");

	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= FRAME_LEN)
		else $error("write position beyond frame store");

	a_tick_advance: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_axis_tuser == lcw_pkg::OP_TICK && phase_q == lcw_pkg::PH_RUN
		|=> wp_q == $past(wp_q) + 1'b1)
		else $error("tick did not advance write position");

endmodule

/* rtl/lcw_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; contents are undefined until written.
module lcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* tb/lcw_format80_decompressor_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for lcw_format80_decompressor: drives LCW command streams, ticks and
// stray beats, predicts every result beat and compares it field by field.
// Depends on lcw_pkg and the decompressor RTL only.
module lcw_format80_decompressor_tb;
	import lcw_pkg::*;

	localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;
	localparam logic [7:0] CMD_END   = CMD_SHORT_MASK;
	localparam logic [7:0] CMD_ABS   = CMD_SHORT_MASK | CMD_LONG_MASK;
	localparam logic [7:0] CMD_FILL  = CMD_ABS | {2'b00, CNT_LONG_FILL};
	localparam logic [7:0] CMD_LCOPY = CMD_ABS | {2'b00, CNT_LONG_COPY};
	localparam int FRAME_MAX      = FRAME_BYTES_DEF;
	localparam int BIG_ROOM       = 400;
	localparam int PIPE_LATENCY   = 2;
	localparam int QUIET_LIMIT    = 5000;
	localparam int PHASE_ITEMS    = 250;
	localparam int MAX_PRINTS     = 40;
	localparam int NUM_PHASES     = 8;
	localparam int PHASE_LENGTH [NUM_PHASES] = '{1, 65536, 0, 131071, 40, 300, 4096, 65535};
	localparam int SENDER_IDLE [4]    = '{0, 57, 0, 32};
	localparam int RECEIVER_STALL [4] = '{0, 0, 57, 32};

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  index;
		logic [BYTE_W-1:0]   value;
		logic                run_pending;
	} pixel_beat_t;

	class frame_scoreboard;
		logic [BYTE_W-1:0] store [FRAME_MAX];
		logic [LEN_W-1:0]  length;
		logic [LEN_W-1:0]  wpos;
		phase_t            phase;
		logic [15:0]       run_left;
		logic [15:0]       copy_src;
		logic [7:0]        fill_val;
		logic              is_fill;
		logic [7:0]        held;
		pixel_beat_t       awaited [$];
		int                mismatches;

		function new();
			length = LEN_W'(FRAME_MAX);
			wpos = '0;
			phase = PH_IDLE;
			run_left = '0;
			copy_src = '0;
			fill_val = '0;
			is_fill = 1'b0;
			held = '0;
			mismatches = 0;
		endfunction

		task report(input string msg);
			mismatches++;
			if (mismatches <= MAX_PRINTS) $display("ERROR: %s", msg);
		endtask

		function int usable_length();
			return (int'(length) < FRAME_MAX) ? int'(length) : FRAME_MAX;
		endfunction

		function int room();
			return (int'(wpos) < usable_length()) ? usable_length() - int'(wpos) : 0;
		endfunction

		// Cut the run to the room left; a run cut to nothing is dropped.
		function void arm_run(input int count);
			if (count > room()) count = room();
			run_left = count[15:0];
			phase = (run_left == 0) ? PH_CMD : PH_RUN;
		endfunction

		function void put_pixel(input logic [7:0] v, inout pixel_beat_t r);
			if (int'(wpos) < FRAME_MAX) store[wpos[15:0]] = v;
			r.status = ST_WRITTEN;
			r.index = wpos[15:0];
			r.value = v;
			wpos = wpos + 1'b1;
			run_left = run_left - 1'b1;
			if (run_left == 0) phase = PH_CMD;
		endfunction

		function void decode_byte(input logic [7:0] b, inout pixel_beat_t r);
			int count, distance;
			case (phase)
			PH_CMD: begin
				if ((b & CMD_SHORT_MASK) == 0) begin
					held = b;
					phase = PH_REL2;
				end else if ((b & CMD_LONG_MASK) == 0) begin
					count = int'(b[5:0]);
					if (count == 0) begin
						r.status = ST_ENDED;
						phase = PH_IDLE;
					end else begin
						if (count > room()) count = room();
						run_left = count[15:0];
						phase = (count != 0) ? PH_LIT : PH_CMD;
					end
				end else if (b[5:0] == CNT_LONG_FILL) begin
					phase = PH_FCNT_LO;
				end else if (b[5:0] == CNT_LONG_COPY) begin
					phase = PH_ACNT_LO;
				end else begin
					run_left = 16'(b[5:0]) + 16'(RUN_BIAS);
					phase = PH_ASRC_LO;
				end
			end
			PH_REL2: begin
				count = int'(held[6:4]) + RUN_BIAS;
				distance = int'({held[3:0], b});
				if (int'(wpos) + count > usable_length() || distance == 0 ||
						distance > int'(wpos)) begin
					r.status = ST_STOPPED;
					phase = PH_IDLE;
				end else begin
					copy_src = 16'(int'(wpos) - distance);
					is_fill = 1'b0;
					run_left = count[15:0];
					phase = PH_RUN;
				end
			end
			PH_LIT: put_pixel(b, r);
			PH_FCNT_LO, PH_ACNT_LO: begin
				run_left = {8'h00, b};
				phase = (phase == PH_FCNT_LO) ? PH_FCNT_HI : PH_ACNT_HI;
			end
			PH_FCNT_HI: begin
				run_left = {b, run_left[7:0]};
				phase = PH_FVAL;
			end
			PH_ACNT_HI: begin
				run_left = {b, run_left[7:0]};
				phase = PH_ASRC_LO;
			end
			PH_FVAL: begin
				fill_val = b;
				is_fill = 1'b1;
				arm_run(int'(run_left));
			end
			PH_ASRC_LO: begin
				copy_src = {8'h00, b};
				phase = PH_ASRC_HI;
			end
			PH_ASRC_HI: begin
				copy_src = {b, copy_src[7:0]};
				if (copy_src >= wpos) begin
					r.status = ST_STOPPED;
					phase = PH_IDLE;
				end else begin
					is_fill = 1'b0;
					arm_run(int'(run_left));
				end
			end
			default: r.status = ST_REJECTED;
			endcase
		endfunction

		function void note_accepted(input logic [OP_W-1:0] op, input logic [7:0] b);
			pixel_beat_t r;
			logic [7:0] v;
			r = '0;
			r.status = ST_CONSUMED;
			if (op == OP_START) begin
				wpos = '0;
				run_left = '0;
				phase = PH_CMD;
			end else if (op == OP_TICK) begin
				if (phase != PH_RUN) begin
					r.status = ST_REJECTED;
				end else begin
					v = is_fill ? fill_val : store[copy_src];
					copy_src = copy_src + 1'b1;
					put_pixel(v, r);
				end
			end else if (op == OP_BYTE) begin
				decode_byte(b, r);
			end else begin
				r.status = ST_REJECTED;
			end
			r.run_pending = (phase == PH_RUN);
			awaited.push_back(r);
		endfunction

		task check_result(input logic [STATUS_W-1:0] status, input logic [31:0] data);
			pixel_beat_t want, got;
			got.status = status;
			got.index = data[15:0];
			got.value = data[23:16];
			got.run_pending = data[24];
			if (awaited.size() == 0) begin
				report($sformatf("result beat with nothing awaited: status %0d index %0d",
					got.status, got.index));
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status || got.index !== want.index ||
					got.value !== want.value || got.run_pending !== want.run_pending) begin
				report($sformatf("status %0d/%0d index %0d/%0d value %0h/%0h run %0b/%0b (got/want)",
					got.status, want.status, got.index, want.index,
					got.value, want.value, got.run_pending, want.run_pending));
			end
		endtask

		task finish_check();
			if (awaited.size() != 0)
				report($sformatf("%0d result beats never arrived", awaited.size()));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata = '0;
	logic [OP_W-1:0]     s_axis_tuser = OP_START;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [31:0]         m_axis_tdata;
	logic [STATUS_W-1:0] m_axis_tuser;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [LEN_W-1:0]    cfg_data = '0;

	frame_scoreboard board = new();
	int idle_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;
	int quiet_cycles = 0;

	lcw_format80_decompressor u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tuser, m_axis_tdata);
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("lcw_format80_decompressor regression: fail");
			$finish;
		end
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	task automatic send_item(input logic [OP_W-1:0] op, input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.note_accepted(op, b);
		items_sent++;
	endtask

	// Hold the input side until every awaited beat has come back.
	task automatic drain_hold();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (board.awaited.size() != 0);
	endtask

	task automatic send_noise();
		case ($urandom_range(2))
		0: send_item(OP_UNDEFINED, rand_byte());
		1: send_item(OP_TICK, rand_byte());
		default: send_item(OP_BYTE, rand_byte());
		endcase
	endtask

	// Long counts only where the frame has little room left, so runs stay short.
	function automatic int pick_count();
		if (board.room() <= BIG_ROOM && $urandom_range(99) < 30) return $urandom_range(65535);
		return $urandom_range(24);
	endfunction

	function automatic logic [15:0] pick_source();
		if (board.wpos == 0 || $urandom_range(99) < 10) return 16'($urandom_range(65535));
		return 16'($urandom_range(int'(board.wpos) - 1));
	endfunction

	task automatic send_command();
		int sel, c, distance, wp;
		logic [15:0] src;
		sel = $urandom_range(99);
		wp = int'(board.wpos);
		if (wp == 0 || sel < 30) begin
			c = ($urandom_range(99) < 10) ? $urandom_range(1, 63) : $urandom_range(1, 8);
			send_item(OP_BYTE, CMD_SHORT_MASK | 8'(c));
			// bytes past a truncation get parsed as commands
			repeat (c) send_item(OP_BYTE, rand_byte());
		end else if (sel < 50) begin
			if ($urandom_range(99) < 10)
				distance = $urandom_range(4095);
			else if ($urandom_range(99) < 30)
				distance = 1;
			else
				distance = $urandom_range(1, (wp < 4095) ? wp : 4095);
			c = $urandom_range(7);
			send_item(OP_BYTE, {1'b0, 3'(c), 4'(distance >> 8)});
			send_item(OP_BYTE, 8'(distance));
		end else if (sel < 65) begin
			c = pick_count();
			send_item(OP_BYTE, CMD_FILL);
			send_item(OP_BYTE, 8'(c));
			send_item(OP_BYTE, 8'(c >> 8));
			send_item(OP_BYTE, rand_byte());
		end else if (sel < 80) begin
			src = pick_source();
			send_item(OP_BYTE, CMD_ABS | 8'($urandom_range(61)));
			send_item(OP_BYTE, src[7:0]);
			send_item(OP_BYTE, src[15:8]);
		end else begin
			c = pick_count();
			src = pick_source();
			send_item(OP_BYTE, CMD_LCOPY);
			send_item(OP_BYTE, 8'(c));
			send_item(OP_BYTE, 8'(c >> 8));
			send_item(OP_BYTE, src[7:0]);
			send_item(OP_BYTE, src[15:8]);
		end
	endtask

	task automatic random_step();
		int r;
		r = $urandom_range(99);
		case (board.phase)
		PH_IDLE: begin
			if (r < 6) send_noise();
			else send_item(OP_START, rand_byte());
		end
		PH_RUN: begin
			if (r < 3) send_noise();
			else if (r < 4) send_item(OP_START, rand_byte());
			else send_item(OP_TICK, rand_byte());
		end
		PH_CMD: begin
			if (r < 8) send_item(OP_BYTE, CMD_END);
			else send_command();
		end
		default: begin
			// keep stray long counts small while the frame has plenty of room
			if ((board.phase == PH_FCNT_HI || board.phase == PH_ACNT_HI) &&
					board.room() > BIG_ROOM)
				send_item(OP_BYTE, 8'h00);
			else
				send_item(OP_BYTE, rand_byte());
		end
		endcase
	endtask

	initial begin
		int first;
		bit paused;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: rejects, literals, copy at distance one, fill, short copy, end, bad distance
		send_item(OP_BYTE, 8'h55);
		send_item(OP_TICK, 8'h00);
		send_item(OP_UNDEFINED, 8'hFF);
		send_item(OP_START, 8'h00);
		send_item(OP_BYTE, CMD_SHORT_MASK | 8'd2);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'h01);
		send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, 8'h12);
		send_item(OP_TICK, 8'hFF);
		send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, CMD_FILL);
		send_item(OP_BYTE, 8'h01);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'hA5);
		send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, CMD_ABS);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'h00);
		repeat (3) send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, CMD_END);
		send_item(OP_START, 8'h00);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'h00);

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_hold();
			repeat (PIPE_LATENCY) @(posedge clk);
			cfg_data <= LEN_W'(PHASE_LENGTH[p]);
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			cfg_valid <= 1'b0;
			board.length = LEN_W'(PHASE_LENGTH[p]);

			idle_pct = SENDER_IDLE[p % 4];
			stall_pct = RECEIVER_STALL[p % 4];
			first = items_sent;
			paused = 1'b0;
			// a phase may end mid-frame, so the next length applies to a running frame
			while (items_sent - first < PHASE_ITEMS) begin
				if (!paused && items_sent - first >= PHASE_ITEMS / 2) begin
					drain_hold();
					paused = 1'b1;
				end
				random_step();
			end
		end

		drain_hold();
		repeat (4 * PIPE_LATENCY) @(posedge clk);
		board.finish_check();
		if (board.mismatches == 0)
			$display("lcw_format80_decompressor regression: pass");
		else
			$display("lcw_format80_decompressor regression: fail");
		$finish;
	end

endmodule

/* lcw_format80_decompressor.f */
rtl/lcw_pkg.sv
rtl/lcw_ram.sv
rtl/lcw_format80_decompressor.sv
tb/lcw_format80_decompressor_tb.sv
